// File: sv/cscv_pkg.sv
// Shared types, constants and calendar tables for the calendar seconds converter.
// No dependencies.
package cscv_pkg;

  localparam logic [31:0] DAY_SECS       = 32'd86400;
  localparam logic [26:0] CYCLE_SECS     = 27'd126230400;
  localparam logic [26:0] LEAP_YEAR_SECS = 27'd31622400;
  localparam logic [26:0] COMMON_YR_SECS = 27'd31536000;
  localparam logic [26:0] HOUR_SECS      = 27'd3600;
  localparam logic [26:0] MIN_SECS       = 27'd60;
  localparam logic [26:0] WEEK_DAYS      = 27'd7;
  localparam int          DIV_RW         = 27;

  typedef enum logic [1:0] {
    CMD_TO_SECS = 2'd0,
    CMD_TO_DATE = 2'd1,
    CMD_SET     = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_C_GO, S_C_WT, S_YLEAP, S_YCOM, S_MONTH, S_D_GO, S_D_WT,
    S_H_GO, S_H_WT, S_M_GO, S_M_WT, S_DAYS, S_MUL_GO, S_MUL_WT,
    S_W_GO, S_W_WT, S_W7_GO, S_W7_WT, S_FINISH
  } state_t;

  // Cumulative days before month (idx 0 = January, idx 12 = full year)
  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
    logic [8:0] v;
    unique case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = leap ? 9'd60  : 9'd59;
      4'd3:    v = leap ? 9'd91  : 9'd90;
      4'd4:    v = leap ? 9'd121 : 9'd120;
      4'd5:    v = leap ? 9'd152 : 9'd151;
      4'd6:    v = leap ? 9'd182 : 9'd181;
      4'd7:    v = leap ? 9'd213 : 9'd212;
      4'd8:    v = leap ? 9'd244 : 9'd243;
      4'd9:    v = leap ? 9'd274 : 9'd273;
      4'd10:   v = leap ? 9'd305 : 9'd304;
      4'd11:   v = leap ? 9'd335 : 9'd334;
      default: v = leap ? 9'd366 : 9'd365;
    endcase
    return v;
  endfunction

  // Same table scaled to seconds
  function automatic logic [24:0] cum_secs(input logic leap, input logic [3:0] idx);
    logic [24:0] v;
    unique case (idx)
      4'd0:    v = 25'd0;
      4'd1:    v = 25'd2678400;
      4'd2:    v = leap ? 25'd5184000  : 25'd5097600;
      4'd3:    v = leap ? 25'd7862400  : 25'd7776000;
      4'd4:    v = leap ? 25'd10454400 : 25'd10368000;
      4'd5:    v = leap ? 25'd13132800 : 25'd13046400;
      4'd6:    v = leap ? 25'd15724800 : 25'd15638400;
      4'd7:    v = leap ? 25'd18403200 : 25'd18316800;
      4'd8:    v = leap ? 25'd21081600 : 25'd20995200;
      4'd9:    v = leap ? 25'd23673600 : 25'd23587200;
      4'd10:   v = leap ? 25'd26352000 : 25'd26265600;
      4'd11:   v = leap ? 25'd28944000 : 25'd28857600;
      default: v = leap ? 25'd31622400 : 25'd31536000;
    endcase
    return v;
  endfunction

endpackage

// File: sv/cscv_div.sv
// Bit-serial restoring divider: 32-bit dividend by a divisor below 2^27.
// Depends on cscv_pkg.
module cscv_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [31:0]                dividend,
  input  logic [cscv_pkg::DIV_RW-1:0] divisor,
  output logic                       done,
  output logic [31:0]                quo,
  output logic [cscv_pkg::DIV_RW-1:0] rem
);
  import cscv_pkg::*;

  logic [31:0]     dvd;
  logic [DIV_RW-1:0] dsr;
  logic [4:0]      cnt;
  logic            busy;
  logic [DIV_RW:0] trial;
  logic            fits;

  assign trial = {rem, dvd[31]};
  assign fits  = trial >= {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[30:0], 1'b0};
      quo <= {quo[30:0], fits};
      rem <= fits ? DIV_RW'(trial - {1'b0, dsr}) : trial[DIV_RW-1:0];
    end
  end

endmodule

// File: sv/cscv_mul.sv
// Bit-serial multiply of a day count by the seconds in a day, modulo 2^32.
// Depends on cscv_pkg.
module cscv_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] days,
  output logic        done,
  output logic [31:0] prod
);
  import cscv_pkg::*;

  logic [31:0] mc;
  logic [4:0]  cnt;
  logic        busy;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // msb first shift-add
  always_ff @(posedge clk) begin
    if (start) begin
      mc   <= days;
      prod <= '0;
    end else if (busy) begin
      mc   <= {mc[30:0], 1'b0};
      prod <= {prod[30:0], 1'b0} + (mc[31] ? DAY_SECS : 32'd0);
    end
  end

endmodule

// File: sv/calendar_seconds_converter_core.sv
// Top level: request handshakes, sequencer and datapath of the converter.
// Depends on cscv_pkg, cscv_div and cscv_mul.
//
//  channel   signals                         direction
//  request   in_valid/in_ready + in_* fields  in
//  result    out_valid/out_ready + out_*      out
//  config    cfg_we/cfg_wdata (base_year)     in
//
// Seconds to date runs a serial division by the four-year cycle, a year search,
// a month search and serial divisions for day, hour and minute; date to seconds
// runs a serial multiply. Both then run serial divisions for the weekday.
// Synchronous reset: base year 2000, weekday offset 0, idle and empty.
// A new request is taken while the previous result waits in the output register.
// Command 3 is taken and dropped without a result.
module calendar_seconds_converter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] in_seconds,
  input  logic [11:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_second,
  input  logic [2:0]  in_weekday,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_seconds,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [2:0]  out_weekday
);
  import cscv_pkg::*;

  state_t state, state_next;

  logic [11:0] base_year;
  logic [2:0]  weekday_offset;
  cmd_t        cmd;
  logic [31:0] secs;
  logic [11:0] f_year;
  logic [3:0]  f_month;
  logic [4:0]  f_day;
  logic [4:0]  f_hour;
  logic [5:0]  f_minute;
  logic [5:0]  f_second;
  logic [2:0]  f_wday;
  logic [5:0]  cyc;
  logic [1:0]  yr;
  logic [DIV_RW-1:0] rem;
  logic [31:0] days;
  logic [31:0] wdays;
  logic [2:0]  wres;

  logic              div_start, div_done;
  logic [31:0]       div_a, div_q;
  logic [DIV_RW-1:0] div_d, div_r;
  logic              mul_start, mul_done;
  logic [31:0]       mul_p;

  logic        accept;
  logic        leap_cur;
  logic [24:0] month_top, month_base;
  logic [11:0] diff;
  logic [11:0] leaps;
  logic        leap_in;
  logic [3:0]  idx;
  logic [31:0] days_calc;
  logic [31:0] tod;
  logic [2:0]  tgt;
  logic [2:0]  q7;
  logic [3:0]  wsum;
  logic [2:0]  off_set;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);

  cscv_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_d),
    .done(div_done), .quo(div_q), .rem(div_r)
  );

  cscv_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .days(days), .done(mul_done), .prod(mul_p)
  );

  // date to day count
  always_comb begin
    diff    = (f_year > base_year) ? f_year - base_year : 12'd0;
    leaps   = (diff == 12'd0) ? 12'd0 : ((diff - 12'd1) >> 2) + 12'd1;
    leap_in = (diff[1:0] == 2'd0);
    if (f_month == 4'd0) begin
      idx = 4'd0;
    end else if (f_month > 4'd13) begin
      idx = 4'd12;
    end else begin
      idx = f_month - 4'd1;
    end
    days_calc = 32'(diff) * 32'd365 + 32'(leaps) + 32'(cum_days(leap_in, idx))
                + 32'(f_day) - 32'd1;
    tod = 32'(f_hour) * 32'd3600 + 32'(f_minute) * 32'd60 + 32'(f_second);
  end

  // month search bounds
  assign leap_cur   = (yr == 2'd0);
  assign month_top  = cum_secs(leap_cur, f_month);
  assign month_base = cum_secs(leap_cur, f_month - 4'd1);

  // weekday arithmetic
  always_comb begin
    tgt  = (f_wday == 3'd0) ? 3'd6 : f_wday - 3'd1;
    q7   = div_r[2:0];
    wsum = 4'(q7) + 4'(weekday_offset);
    if (wsum >= 4'd7) begin
      wsum = wsum - 4'd7;
    end
    off_set = (tgt >= q7) ? tgt - q7 : 3'(4'(tgt) + 4'd7 - 4'(q7));
  end

  // sequencer
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    mul_start  = 1'b0;
    div_a      = secs;
    div_d      = CYCLE_SECS;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority case (cmd_t'(command))
            CMD_TO_DATE: state_next = S_C_GO;
            CMD_NONE:    state_next = S_IDLE;
            default:     state_next = S_DAYS;
          endcase
        end
      end
      S_C_GO: begin
        div_start  = 1'b1;
        state_next = S_C_WT;
      end
      S_C_WT:   if (div_done) state_next = S_YLEAP;
      S_YLEAP:  state_next = (rem >= LEAP_YEAR_SECS) ? S_YCOM : S_MONTH;
      S_YCOM: begin
        if (!(yr != 2'd3 && rem >= COMMON_YR_SECS)) begin
          state_next = S_MONTH;
        end
      end
      S_MONTH: begin
        if (!(f_month < 4'd12 && rem >= 27'(month_top))) begin
          state_next = S_D_GO;
        end
      end
      S_D_GO: begin
        div_a      = 32'(rem);
        div_d      = 27'(DAY_SECS);
        div_start  = 1'b1;
        state_next = S_D_WT;
      end
      S_D_WT:   if (div_done) state_next = S_H_GO;
      S_H_GO: begin
        div_a      = 32'(rem);
        div_d      = HOUR_SECS;
        div_start  = 1'b1;
        state_next = S_H_WT;
      end
      S_H_WT:   if (div_done) state_next = S_M_GO;
      S_M_GO: begin
        div_a      = 32'(rem);
        div_d      = MIN_SECS;
        div_start  = 1'b1;
        state_next = S_M_WT;
      end
      S_M_WT:   if (div_done) state_next = S_W_GO;
      S_DAYS:   state_next = S_MUL_GO;
      S_MUL_GO: begin
        mul_start  = 1'b1;
        state_next = S_MUL_WT;
      end
      S_MUL_WT: if (mul_done) state_next = S_W_GO;
      S_W_GO: begin
        div_a      = secs;
        div_d      = 27'(DAY_SECS);
        div_start  = 1'b1;
        state_next = S_W_WT;
      end
      S_W_WT:   if (div_done) state_next = S_W7_GO;
      S_W7_GO: begin
        div_a      = wdays;
        div_d      = WEEK_DAYS;
        div_start  = 1'b1;
        state_next = S_W7_WT;
      end
      S_W7_WT:  if (div_done) state_next = S_FINISH;
      S_FINISH: if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_year      <= 12'd2000;
      weekday_offset <= 3'd0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_year <= cfg_wdata;
      end
      if (state == S_W7_WT && div_done && cmd == CMD_SET) begin
        weekday_offset <= off_set;
      end
      if (state == S_FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd      <= cmd_t'(command);
      secs     <= in_seconds;
      f_year   <= in_year;
      f_month  <= in_month;
      f_day    <= in_day;
      f_hour   <= in_hour;
      f_minute <= in_minute;
      f_second <= in_second;
      f_wday   <= in_weekday;
      yr       <= 2'd0;
    end
    unique case (state)
      S_C_WT: begin
        if (div_done) begin
          cyc     <= div_q[5:0];
          rem     <= div_r;
          f_month <= 4'd1;
        end
      end
      S_YLEAP: begin
        if (rem >= LEAP_YEAR_SECS) begin
          rem <= rem - LEAP_YEAR_SECS;
          yr  <= 2'd1;
        end
      end
      S_YCOM: begin
        if (yr != 2'd3 && rem >= COMMON_YR_SECS) begin
          rem <= rem - COMMON_YR_SECS;
          yr  <= yr + 2'd1;
        end
      end
      S_MONTH: begin
        if (f_month < 4'd12 && rem >= 27'(month_top)) begin
          f_month <= f_month + 4'd1;
        end else begin
          rem    <= rem - 27'(month_base);
          f_year <= base_year + {4'd0, cyc, 2'b00} + 12'(yr);
        end
      end
      S_D_WT: begin
        if (div_done) begin
          f_day <= div_q[4:0] + 5'd1;
          rem   <= div_r;
        end
      end
      S_H_WT: begin
        if (div_done) begin
          f_hour <= div_q[4:0];
          rem    <= div_r;
        end
      end
      S_M_WT: begin
        if (div_done) begin
          f_minute <= div_q[5:0];
          f_second <= div_r[5:0];
        end
      end
      S_DAYS:   days <= days_calc;
      S_MUL_WT: if (mul_done) secs <= mul_p + tod;
      S_W_WT:   if (div_done) wdays <= div_q;
      S_W7_WT: begin
        if (div_done) begin
          wres <= (cmd == CMD_SET) ? tgt + 3'd1 : wsum[2:0] + 3'd1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!out_valid || out_ready)) begin
      out_seconds <= secs;
      out_year    <= f_year;
      out_month   <= f_month;
      out_day     <= f_day;
      out_hour    <= f_hour;
      out_minute  <= f_minute;
      out_second  <= f_second;
      out_weekday <= wres;
    end
  end

endmodule
